// ----- rtl/core/imb_pkg.sv -----
// Package for the interprocessor mailbox bridge: item structs, command codes,
// register offsets, flag positions and sizing constants. No dependencies.
package imb_pkg;

    localparam int UP_FIFO_DEPTH_DEF = 24;

    typedef enum logic [2:0] {
        CMD_HOST_RD  = 3'd0,
        CMD_HOST_WR  = 3'd1,
        CMD_PAR_RD   = 3'd2,
        CMD_PAR_WR   = 3'd3,
        CMD_RETRY    = 3'd4
    } cmd_t;

    // register offsets in the eight-register window
    localparam logic [2:0] OFF_ST1 = 3'd0;
    localparam logic [2:0] OFF_R1  = 3'd1;
    localparam logic [2:0] OFF_ST2 = 3'd2;
    localparam logic [2:0] OFF_R2  = 3'd3;
    localparam logic [2:0] OFF_ST3 = 3'd4;
    localparam logic [2:0] OFF_R3  = 3'd5;
    localparam logic [2:0] OFF_ST4 = 3'd6;
    localparam logic [2:0] OFF_R4  = 3'd7;

    localparam int FLAG_Q = 0;
    localparam int FLAG_I = 1;
    localparam int FLAG_J = 2;
    localparam int FLAG_M = 3;
    localparam int FLAG_V = 4;
    localparam int BIT_T  = 6;
    localparam int BIT_S  = 7;

    localparam logic [5:0] LOW_ONES = 6'h3F;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] offset;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       host_irq;
        logic       parasite_irq;
        logic       parasite_nmi;
        logic       nmi_edge;
        logic       host_stalled;
        logic       retry_done;
    } out_item_t;

endpackage

// ----- rtl/core/interprocessor_mailbox_bridge.sv -----
// Top level of the interprocessor mailbox bridge: whole register state, one
// access per item and the result register. Depends on imb_pkg.
//
// One item is accepted in every cycle that the result register is free or is
// being taken; its result is registered in the next cycle. All work for an
// item is a single pass through the register file: one latch or FIFO end, the
// control flags and the interrupt logic. The parasite-to-host R1 queue is a
// memory of UP_FIFO_DEPTH bytes with a synchronous read ahead of its head; a
// host read of R1 that follows a parasite write to an empty queue takes the
// byte from a bypass. Reset is immediate, no clearing pass.
module interprocessor_mailbox_bridge #(
    parameter int UP_FIFO_DEPTH = imb_pkg::UP_FIFO_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  imb_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output imb_pkg::out_item_t out_data
);

    localparam int PW = (UP_FIFO_DEPTH > 1) ? $clog2(UP_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(UP_FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(UP_FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(UP_FIFO_DEPTH);

    // latch slots: 0 r1 dn, 1 r2 dn, 2 r2 up, 3 r4 dn, 4 r4 up
    logic [5:0]       flags_reg, flags_next;
    logic [7:0]       hbyte_reg, hbyte_next, pbyte_reg, pbyte_next;
    logic [7:0]       ld_reg [5];
    logic [7:0]       ld_next [5];
    logic [4:0]       lv_reg, lv_next;
    logic [7:0]       dd_reg [2];
    logic [7:0]       dd_next [2];
    logic             dh_reg, dh_next, dt_reg, dt_next, dp_reg, dp_next;
    logic [1:0]       dc_reg, dc_next;
    logic [7:0]       ud_reg [2];
    logic [7:0]       ud_next [2];
    logic             uh_reg, uh_next, ut_reg, ut_next, up_reg, up_next;
    logic [1:0]       uc_reg, uc_next;
    logic [PW-1:0]    fh_reg, fh_next, ft_reg, ft_next;
    logic [CW-1:0]    fc_reg, fc_next;
    logic             nlvl_reg, nlvl_next, nedge_reg, nedge_next;
    logic             stl_reg, stl_next;
    logic [2:0]       soff_reg, soff_next;
    logic [7:0]       sval_reg, sval_next;
    logic [7:0]       mem [UP_FIFO_DEPTH];
    logic [7:0]       head_q;
    logic             byp_reg;
    logic [7:0]       byp_data_reg;
    logic             byp_hit;
    logic             fifo_wr, fifo_rd;
    logic [PW-1:0]    rd_addr;
    logic             accept;
    imb_pkg::out_item_t res;

    assign in_stall = out_valid && out_stall;
    assign accept   = in_valid && !in_stall;

    function automatic logic [PW-1:0] incp(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        logic [7:0] rd, wv;
        logic [2:0] off, woff;
        logic do_wr, done, blk, thr2, cond, lvl;
        flags_next = flags_reg; hbyte_next = hbyte_reg; pbyte_next = pbyte_reg;
        ld_next = ld_reg; lv_next = lv_reg;
        dd_next = dd_reg; dh_next = dh_reg; dt_next = dt_reg; dp_next = dp_reg;
        dc_next = dc_reg;
        ud_next = ud_reg; uh_next = uh_reg; ut_next = ut_reg; up_next = up_reg;
        uc_next = uc_reg;
        fh_next = fh_reg; ft_next = ft_reg; fc_next = fc_reg;
        nlvl_next = nlvl_reg; nedge_next = nedge_reg;
        stl_next = stl_reg; soff_next = soff_reg; sval_next = sval_reg;
        fifo_wr = 1'b0; fifo_rd = 1'b0;
        rd = '0; done = 1'b0; do_wr = 1'b0;
        off = in_data.offset;
        woff = off; wv = in_data.write_data;
        thr2 = flags_reg[imb_pkg::FLAG_V];
        blk = 1'b0;
        case (in_data.cmd)
            imb_pkg::CMD_HOST_RD:
            begin
                unique case (off)
                    imb_pkg::OFF_ST1: rd = {fc_reg != '0, !lv_reg[0], flags_reg};
                    imb_pkg::OFF_R1:
                    begin
                        if (fc_reg != '0)
                        begin
                            rd = byp_reg ? byp_data_reg : head_q;
                            fh_next = incp(fh_reg);
                            fc_next = fc_reg - CW'(1);
                            fifo_rd = 1'b1;
                        end
                        else
                            rd = pbyte_reg;
                    end
                    imb_pkg::OFF_ST2: rd = {lv_reg[2], !lv_reg[1], imb_pkg::LOW_ONES};
                    imb_pkg::OFF_R2:
                    begin
                        rd = ld_reg[2];
                        lv_next[2] = 1'b0;
                    end
                    imb_pkg::OFF_ST3: rd = {up_reg || (uc_reg >= (thr2 ? 2'd2 : 2'd1)), !dp_reg,
                                imb_pkg::LOW_ONES};
                    imb_pkg::OFF_R3:
                    begin
                        if (uc_reg != 2'd0)
                        begin
                            rd = ud_reg[uh_reg];
                            uh_next = !uh_reg;
                            uc_next = uc_reg - 2'd1;
                            if (uc_next == 2'd0) up_next = 1'b0;
                        end
                        else
                            rd = pbyte_reg;
                    end
                    imb_pkg::OFF_ST4: rd = {lv_reg[4], !lv_reg[3], imb_pkg::LOW_ONES};
                    default:
                    begin
                        rd = ld_reg[4];
                        lv_next[4] = 1'b0;
                    end
                endcase
            end
            imb_pkg::CMD_HOST_WR: do_wr = 1'b1;
            imb_pkg::CMD_RETRY:
            begin
                woff = soff_reg; wv = sval_reg;
                blk = (woff == imb_pkg::OFF_R1 && lv_reg[0])
                   || (woff == imb_pkg::OFF_R3 && dc_reg == 2'd2)
                   || (woff == imb_pkg::OFF_R4 && lv_reg[3]);
                if (!stl_reg)
                    done = 1'b1;
                else if (!blk)
                begin
                    stl_next = 1'b0; do_wr = 1'b1; done = 1'b1;
                end
            end
            imb_pkg::CMD_PAR_RD:
            begin
                unique case (off)
                    imb_pkg::OFF_ST1: rd = {lv_reg[0], fc_reg < FULL_CNT, flags_reg};
                    imb_pkg::OFF_R1:
                    begin
                        rd = ld_reg[0];
                        lv_next[0] = 1'b0;
                    end
                    imb_pkg::OFF_ST2: rd = {lv_reg[1], !lv_reg[2], imb_pkg::LOW_ONES};
                    imb_pkg::OFF_R2:
                    begin
                        rd = ld_reg[1];
                        lv_next[1] = 1'b0;
                    end
                    imb_pkg::OFF_ST3: rd = {dp_reg || (dc_reg >= (thr2 ? 2'd2 : 2'd1)) || !up_reg,
                                !up_reg, imb_pkg::LOW_ONES};
                    imb_pkg::OFF_R3:
                    begin
                        if (dc_reg != 2'd0)
                        begin
                            rd = dd_reg[dh_reg];
                            dh_next = !dh_reg;
                            dc_next = dc_reg - 2'd1;
                            if (dc_next == 2'd0) dp_next = 1'b0;
                        end
                        else
                            rd = hbyte_reg;
                    end
                    imb_pkg::OFF_ST4: rd = {lv_reg[3], !lv_reg[4], imb_pkg::LOW_ONES};
                    default:
                    begin
                        rd = ld_reg[3];
                        lv_next[3] = 1'b0;
                    end
                endcase
            end
            imb_pkg::CMD_PAR_WR:
            begin
                pbyte_next = wv;
                case (off)
                    imb_pkg::OFF_R1:
                        if (fc_reg < FULL_CNT)
                        begin
                            fifo_wr = 1'b1;
                            ft_next = incp(ft_reg);
                            fc_next = fc_reg + CW'(1);
                        end
                    imb_pkg::OFF_R2:
                    begin
                        ld_next[2] = wv;
                        lv_next[2] = 1'b1;
                    end
                    imb_pkg::OFF_R3:
                        if (uc_reg < 2'd2)
                        begin
                            ud_next[ut_reg] = wv;
                            ut_next = !ut_reg;
                            uc_next = uc_reg + 2'd1;
                            if (uc_next >= (thr2 ? 2'd2 : 2'd1)) up_next = 1'b1;
                        end
                    imb_pkg::OFF_R4:
                    begin
                        ld_next[4] = wv;
                        lv_next[4] = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (do_wr)
        begin
            hbyte_next = wv;
            blk = (woff == imb_pkg::OFF_R1 && lv_reg[0])
               || (woff == imb_pkg::OFF_R3 && dc_reg == 2'd2)
               || (woff == imb_pkg::OFF_R4 && lv_reg[3]);
            if (blk)
            begin
                stl_next = 1'b1; soff_next = woff; sval_next = wv;
            end
            else
            begin
                case (woff)
                    imb_pkg::OFF_ST1:
                    begin
                        if (wv[imb_pkg::BIT_S])
                        begin
                            if (wv[imb_pkg::BIT_T])
                            begin
                                // soft reset of all queues and latches
                                fh_next = '0; ft_next = '0; fc_next = '0;
                                for (int i = 0; i < 5; i++) ld_next[i] = '0;
                                lv_next = '0;
                                dd_next[0] = '0; dd_next[1] = '0;
                                dh_next = 1'b0; dt_next = 1'b0; dc_next = 2'd0;
                                dp_next = 1'b0;
                                ud_next[0] = '0; ud_next[1] = '0;
                                uh_next = 1'b0; ut_next = 1'b1; uc_next = 2'd1;
                                up_next = 1'b1;
                                nlvl_next = 1'b0; nedge_next = 1'b0;
                                stl_next = 1'b0; soff_next = '0; sval_next = '0;
                            end
                            flags_next = flags_reg | wv[5:0];
                        end
                        else
                            flags_next = flags_reg & ~wv[5:0];
                    end
                    imb_pkg::OFF_R1:
                    begin
                        ld_next[0] = wv;
                        lv_next[0] = 1'b1;
                    end
                    imb_pkg::OFF_R2:
                    begin
                        ld_next[1] = wv;
                        lv_next[1] = 1'b1;
                    end
                    imb_pkg::OFF_R3:
                    begin
                        dd_next[dt_reg] = wv;
                        dt_next = !dt_reg;
                        dc_next = dc_reg + 2'd1;
                        if (dc_next >= (thr2 ? 2'd2 : 2'd1)) dp_next = 1'b1;
                    end
                    imb_pkg::OFF_R4:
                    begin
                        ld_next[3] = wv;
                        lv_next[3] = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        // interrupt levels from the new state
        cond = dp_next || (dc_next >= (flags_next[imb_pkg::FLAG_V] ? 2'd2 : 2'd1))
            || !up_next;
        lvl = flags_next[imb_pkg::FLAG_M] && cond;
        if (lvl && !nlvl_next) nedge_next = 1'b1;
        if (!lvl) nedge_next = 1'b0;
        if (in_data.cmd == imb_pkg::CMD_HOST_RD || in_data.cmd == imb_pkg::CMD_HOST_WR
            || in_data.cmd == imb_pkg::CMD_PAR_RD || in_data.cmd == imb_pkg::CMD_PAR_WR
            || in_data.cmd == imb_pkg::CMD_RETRY)
            nlvl_next = lvl;
        else
        begin
            nlvl_next = nlvl_reg; nedge_next = nedge_reg;
        end

        res.read_data    = rd;
        res.host_irq     = flags_next[imb_pkg::FLAG_Q] && lv_next[4];
        res.parasite_irq = (flags_next[imb_pkg::FLAG_I] && lv_next[0])
                        || (flags_next[imb_pkg::FLAG_J] && lv_next[3]);
        res.parasite_nmi = nlvl_next;
        res.nmi_edge     = nedge_next;
        res.host_stalled = stl_next;
        res.retry_done   = done;
    end

    // queue memory: read one ahead of the head pointer
    assign rd_addr = fifo_rd ? incp(fh_reg) : fh_reg;
    assign byp_hit = fifo_wr && (ft_reg == rd_addr);

    always_ff @(posedge clk)
    begin
        if (accept && fifo_wr)
            mem[ft_reg] <= in_data.write_data;
        if (accept)
            head_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
            byp_data_reg <= '0;
        end
        else if (accept)
        begin
            // a write landing on the next head address misses the registered read;
            // hold an earlier bypass until the head moves on
            byp_reg <= byp_hit || (byp_reg && !fifo_rd);
            byp_data_reg <= byp_hit ? in_data.write_data : byp_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0; hbyte_reg <= '0; pbyte_reg <= '0;
            for (int i = 0; i < 5; i++) ld_reg[i] <= '0;
            lv_reg <= '0;
            dd_reg[0] <= '0; dd_reg[1] <= '0;
            dh_reg <= 1'b0; dt_reg <= 1'b0; dc_reg <= 2'd0; dp_reg <= 1'b0;
            ud_reg[0] <= '0; ud_reg[1] <= '0;
            uh_reg <= 1'b0; ut_reg <= 1'b1; uc_reg <= 2'd1; up_reg <= 1'b1;
            fh_reg <= '0; ft_reg <= '0; fc_reg <= '0;
            nlvl_reg <= 1'b0; nedge_reg <= 1'b0;
            stl_reg <= 1'b0; soff_reg <= '0; sval_reg <= '0;
            out_valid <= 1'b0;
            out_data <= '0;
        end
        else
        begin
            if (accept)
            begin
                flags_reg <= flags_next; hbyte_reg <= hbyte_next; pbyte_reg <= pbyte_next;
                ld_reg <= ld_next; lv_reg <= lv_next;
                dd_reg <= dd_next; dh_reg <= dh_next; dt_reg <= dt_next;
                dc_reg <= dc_next; dp_reg <= dp_next;
                ud_reg <= ud_next; uh_reg <= uh_next; ut_reg <= ut_next;
                uc_reg <= uc_next; up_reg <= up_next;
                fh_reg <= fh_next; ft_reg <= ft_next; fc_reg <= fc_next;
                nlvl_reg <= nlvl_next; nedge_reg <= nedge_next;
                stl_reg <= stl_next; soff_reg <= soff_next; sval_reg <= sval_next;
                out_data <= res;
                out_valid <= 1'b1;
            end
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    // queue count never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n) fc_reg <= FULL_CNT)
        else $error("up queue overflow");

    // edge flag only while the level is high
    assert property (@(posedge clk) disable iff (!rst_n) nedge_reg |-> nlvl_reg)
        else $error("nmi edge without level");

    // R3 up queue pending implies data held
    assert property (@(posedge clk) disable iff (!rst_n) up_reg |-> (uc_reg != 2'd0))
        else $error("r3 pending with empty queue");

endmodule

// ----- bench/tb_top.sv -----
// Testbench for interprocessor_mailbox_bridge: predicts each mailbox access and
// checks every result item in order. Depends on imb_pkg and the bridge RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = imb_pkg::UP_FIFO_DEPTH_DEF;
    localparam int LIMIT = 600000;

    // latch slots
    localparam int LR1_DN = 0;
    localparam int LR2_DN = 1;
    localparam int LR2_UP = 2;
    localparam int LR4_DN = 3;
    localparam int LR4_UP = 4;

    class mailbox_scoreboard;
        logic [5:0] flags;
        logic [7:0] host_byte, par_byte;
        logic [7:0] up_q[DEPTH];
        int up_head, up_tail, up_cnt;
        logic [7:0] lat_d[5];
        bit lat_v[5];
        logic [7:0] dn3_d[2], up3_d[2];
        int dn3_h, dn3_t, dn3_c, up3_h, up3_t, up3_c;
        bit dn3_p, up3_p;
        bit irq_h, irq_p, nmi_lvl, nmi_edg;
        bit held;
        logic [2:0] held_off;
        logic [7:0] held_val;
        imb_pkg::out_item_t pending_q[$];
        int errors;

        function new();
            errors = 0;
            flags = 0; host_byte = 0; par_byte = 0;
            clear_queues();
        endfunction

        function int thresh();
            return flags[imb_pkg::FLAG_V] ? 2 : 1;
        endfunction

        function bit nmi_cond();
            return dn3_p || dn3_c >= thresh() || !up3_p;
        endfunction

        function void update_irqs();
            bit lvl;
            irq_h = flags[imb_pkg::FLAG_Q] && lat_v[LR4_UP];
            irq_p = (flags[imb_pkg::FLAG_I] && lat_v[LR1_DN])
                 || (flags[imb_pkg::FLAG_J] && lat_v[LR4_DN]);
            lvl = flags[imb_pkg::FLAG_M] && nmi_cond();
            if (lvl && !nmi_lvl) nmi_edg = 1;
            if (!lvl) nmi_edg = 0;
            nmi_lvl = lvl;
        endfunction

        function void clear_queues();
            foreach (up_q[i]) up_q[i] = 0;
            up_head = 0; up_tail = 0; up_cnt = 0;
            foreach (lat_d[i])
            begin
                lat_d[i] = 0;
                lat_v[i] = 0;
            end
            dn3_d[0] = 0; dn3_d[1] = 0; up3_d[0] = 0; up3_d[1] = 0;
            dn3_h = 0; dn3_t = 0; dn3_c = 0; dn3_p = 0;
            up3_h = 0; up3_t = 1; up3_c = 1; up3_p = 1;
            irq_h = 0; irq_p = 0; nmi_lvl = 0; nmi_edg = 0;
            held = 0; held_off = 0; held_val = 0;
            update_irqs();
        endfunction

        function logic [7:0] status(logic [5:0] low, bit d, bit s);
            return {d, s, low};
        endfunction

        function logic [7:0] take_latch(int i);
            lat_v[i] = 0;
            return lat_d[i];
        endfunction

        function bit host_blocked(logic [2:0] off);
            if (off == imb_pkg::OFF_R1) return lat_v[LR1_DN];
            if (off == imb_pkg::OFF_R3) return dn3_c >= 2;
            if (off == imb_pkg::OFF_R4) return lat_v[LR4_DN];
            return 0;
        endfunction

        function void pair_put(bit down, logic [7:0] v);
            if (down)
            begin
                dn3_d[dn3_t] = v; dn3_t ^= 1; dn3_c++;
                if (dn3_c >= thresh()) dn3_p = 1;
            end
            else
            begin
                up3_d[up3_t] = v; up3_t ^= 1; up3_c++;
                if (up3_c >= thresh()) up3_p = 1;
            end
        endfunction

        function logic [7:0] pair_take(bit down);
            logic [7:0] v;
            if (down)
            begin
                v = dn3_d[dn3_h]; dn3_h ^= 1; dn3_c--;
                if (dn3_c == 0) dn3_p = 0;
            end
            else
            begin
                v = up3_d[up3_h]; up3_h ^= 1; up3_c--;
                if (up3_c == 0) up3_p = 0;
            end
            return v;
        endfunction

        function logic [7:0] host_rd_access(logic [2:0] off);
            logic [7:0] r;
            case (off)
                imb_pkg::OFF_ST1: r = status(flags, up_cnt > 0, !lat_v[LR1_DN]);
                imb_pkg::OFF_R1:
                begin
                    if (up_cnt > 0)
                    begin
                        r = up_q[up_head];
                        up_head = (up_head + 1 >= DEPTH) ? 0 : up_head + 1;
                        up_cnt--;
                    end
                    else
                        r = par_byte;
                end
                imb_pkg::OFF_ST2:
                    r = status(imb_pkg::LOW_ONES, lat_v[LR2_UP], !lat_v[LR2_DN]);
                imb_pkg::OFF_R2: r = take_latch(LR2_UP);
                imb_pkg::OFF_ST3:
                    r = status(imb_pkg::LOW_ONES, up3_p || up3_c >= thresh(), !dn3_p);
                imb_pkg::OFF_R3: r = (up3_c > 0) ? pair_take(0) : par_byte;
                imb_pkg::OFF_ST4:
                    r = status(imb_pkg::LOW_ONES, lat_v[LR4_UP], !lat_v[LR4_DN]);
                default: r = take_latch(LR4_UP);
            endcase
            update_irqs();
            return r;
        endfunction

        function void host_wr_access(logic [2:0] off, logic [7:0] v);
            host_byte = v;
            if (host_blocked(off))
            begin
                held = 1; held_off = off; held_val = v;
                update_irqs();
                return;
            end
            case (off)
                imb_pkg::OFF_ST1:
                begin
                    if (v[imb_pkg::BIT_S])
                    begin
                        if (v[imb_pkg::BIT_T]) clear_queues();
                        flags = flags | v[5:0];
                    end
                    else
                        flags = flags & ~v[5:0];
                end
                imb_pkg::OFF_R1:
                begin
                    lat_d[LR1_DN] = v;
                    lat_v[LR1_DN] = 1;
                end
                imb_pkg::OFF_R2:
                begin
                    lat_d[LR2_DN] = v;
                    lat_v[LR2_DN] = 1;
                end
                imb_pkg::OFF_R3: pair_put(1, v);
                imb_pkg::OFF_R4:
                begin
                    lat_d[LR4_DN] = v;
                    lat_v[LR4_DN] = 1;
                end
                default: ;
            endcase
            update_irqs();
        endfunction

        function logic [7:0] par_read(logic [2:0] off);
            logic [7:0] r;
            case (off)
                imb_pkg::OFF_ST1: r = status(flags, lat_v[LR1_DN], up_cnt < DEPTH);
                imb_pkg::OFF_R1: r = take_latch(LR1_DN);
                imb_pkg::OFF_ST2:
                    r = status(imb_pkg::LOW_ONES, lat_v[LR2_DN], !lat_v[LR2_UP]);
                imb_pkg::OFF_R2: r = take_latch(LR2_DN);
                imb_pkg::OFF_ST3: r = status(imb_pkg::LOW_ONES, nmi_cond(), !up3_p);
                imb_pkg::OFF_R3: r = (dn3_c > 0) ? pair_take(1) : host_byte;
                imb_pkg::OFF_ST4:
                    r = status(imb_pkg::LOW_ONES, lat_v[LR4_DN], !lat_v[LR4_UP]);
                default: r = take_latch(LR4_DN);
            endcase
            update_irqs();
            return r;
        endfunction

        function void par_write(logic [2:0] off, logic [7:0] v);
            par_byte = v;
            case (off)
                imb_pkg::OFF_R1:
                    if (up_cnt < DEPTH)
                    begin
                        up_q[up_tail] = v;
                        up_tail = (up_tail + 1 >= DEPTH) ? 0 : up_tail + 1;
                        up_cnt++;
                    end
                imb_pkg::OFF_R2:
                begin
                    lat_d[LR2_UP] = v;
                    lat_v[LR2_UP] = 1;
                end
                imb_pkg::OFF_R3: if (up3_c < 2) pair_put(0, v);
                imb_pkg::OFF_R4:
                begin
                    lat_d[LR4_UP] = v;
                    lat_v[LR4_UP] = 1;
                end
                default: ;
            endcase
            update_irqs();
        endfunction

        // note an accepted access and queue its expected result
        function void note_access(imb_pkg::in_item_t it);
            imb_pkg::out_item_t e;
            e = '0;
            case (it.cmd)
                imb_pkg::CMD_HOST_RD: e.read_data = host_rd_access(it.offset);
                imb_pkg::CMD_HOST_WR: host_wr_access(it.offset, it.write_data);
                imb_pkg::CMD_PAR_RD:  e.read_data = par_read(it.offset);
                imb_pkg::CMD_PAR_WR:  par_write(it.offset, it.write_data);
                imb_pkg::CMD_RETRY:
                begin
                    if (!held)
                        e.retry_done = 1;
                    else if (!host_blocked(held_off))
                    begin
                        held = 0;
                        host_wr_access(held_off, held_val);
                        e.retry_done = 1;
                    end
                end
                default: ;
            endcase
            e.host_irq = irq_h;
            e.parasite_irq = irq_p;
            e.parasite_nmi = nmi_lvl;
            e.nmi_edge = nmi_edg;
            e.host_stalled = held;
            pending_q.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(imb_pkg::out_item_t got);
            imb_pkg::out_item_t e;
            if (pending_q.size() == 0)
            begin
                report("unexpected result item", got, 0);
                return;
            end
            e = pending_q.pop_front();
            if (got.read_data !== e.read_data) report("read_data", got.read_data, e.read_data);
            if (got.host_irq !== e.host_irq) report("host_irq", got.host_irq, e.host_irq);
            if (got.parasite_irq !== e.parasite_irq)
                report("parasite_irq", got.parasite_irq, e.parasite_irq);
            if (got.parasite_nmi !== e.parasite_nmi)
                report("parasite_nmi", got.parasite_nmi, e.parasite_nmi);
            if (got.nmi_edge !== e.nmi_edge) report("nmi_edge", got.nmi_edge, e.nmi_edge);
            if (got.host_stalled !== e.host_stalled)
                report("host_stalled", got.host_stalled, e.host_stalled);
            if (got.retry_done !== e.retry_done)
                report("retry_done", got.retry_done, e.retry_done);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    imb_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    imb_pkg::out_item_t out_data;

    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;
    mailbox_scoreboard sb;

    interprocessor_mailbox_bridge u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // receiver: check accepted results, then choose next stall
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // present one item, hold it until taken; drop valid only while idling
    task automatic send(logic [2:0] c, logic [2:0] off, logic [7:0] wd);
        imb_pkg::in_item_t it;
        it.cmd = c; it.offset = off; it.write_data = wd;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        sb.note_access(it);
    endtask

    // mostly well-formed mailbox traffic with random bytes, some noise
    task automatic random_item();
        int k;
        logic [2:0] off;
        k = $urandom_range(99);
        off = {2'($urandom_range(3)), 1'b1};
        if (k < 4)
            send(3'($urandom_range(7)), 3'($urandom), 8'($urandom));
        else if (k < 8)
            send(imb_pkg::CMD_HOST_WR, imb_pkg::OFF_ST1, 8'($urandom));
        else if (k < 14)
            send(imb_pkg::CMD_RETRY, 3'($urandom), 8'($urandom));
        else if (k < 22)
            send(k[0] ? imb_pkg::CMD_HOST_RD : imb_pkg::CMD_PAR_RD,
                 3'($urandom_range(3)) << 1, 8'h00);
        else if (k < 45)
            send(imb_pkg::CMD_PAR_WR, (k < 32) ? imb_pkg::OFF_R1 : off, 8'($urandom));
        else if (k < 68)
            send(imb_pkg::CMD_HOST_RD, (k < 55) ? imb_pkg::OFF_R1 : off, 8'($urandom));
        else if (k < 85)
            send(imb_pkg::CMD_HOST_WR, off, 8'($urandom));
        else
            send(imb_pkg::CMD_PAR_RD, off, 8'($urandom));
    endtask

    task automatic run_phase(int n, int si, int ri);
        send_idle = si;
        recv_idle = ri;
        repeat (n) random_item();
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: status reads, every register, flag set and clear, soft reset
        for (int o = 0; o < 8; o++) send(imb_pkg::CMD_HOST_RD, 3'(o), 8'h00);
        for (int o = 0; o < 8; o++) send(imb_pkg::CMD_PAR_RD, 3'(o), 8'hFF);
        send(imb_pkg::CMD_HOST_WR, imb_pkg::OFF_ST1, 8'hBF);
        send(imb_pkg::CMD_HOST_WR, imb_pkg::OFF_R1, 8'hFF);
        send(imb_pkg::CMD_HOST_WR, imb_pkg::OFF_R1, 8'h00);
        send(imb_pkg::CMD_RETRY, 3'd0, 8'h00);
        send(imb_pkg::CMD_PAR_RD, imb_pkg::OFF_R1, 8'h00);
        send(imb_pkg::CMD_RETRY, 3'd7, 8'hFF);
        send(imb_pkg::CMD_PAR_WR, imb_pkg::OFF_R4, 8'hA5);
        send(3'd5, 3'd7, 8'hFF);
        send(3'd7, 3'd2, 8'h00);
        send(imb_pkg::CMD_HOST_WR, imb_pkg::OFF_ST1, 8'hC0);
        send(imb_pkg::CMD_HOST_WR, imb_pkg::OFF_ST1, 8'h3F);
        for (int i = 0; i < 26; i++) send(imb_pkg::CMD_PAR_WR, imb_pkg::OFF_R1, 8'(i * 9));
        send(imb_pkg::CMD_HOST_WR, imb_pkg::OFF_ST1, 8'h9F);
        run_phase(300, 0, 0);
        run_phase(200, 87, 0);
        run_phase(200, 0, 87);
        run_phase(200, 28, 28);
        run_phase(200, 0, 0);
        in_valid <= 0;
        send_idle = 0;
        recv_idle = 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/imb_pkg.sv
rtl/core/interprocessor_mailbox_bridge.sv
bench/tb_top.sv
